// ----- rtl/dce_pkg.sv -----
// Package for the delimited column extractor: item types, register map and constants.
package dce_pkg;

  localparam int MAX_COLUMN_BYTES = 4096;
  localparam int FLD_W            = $clog2(MAX_COLUMN_BYTES);
  localparam logic [FLD_W-1:0] FLD_LAST = FLD_W'(MAX_COLUMN_BYTES - 1);

  localparam logic [7:0]  QUOTE_BYTE = 8'h22;
  localparam logic [7:0]  TAB_BYTE   = 8'h09;
  localparam logic [15:0] DELIM_MAX  = 16'hFFFF;

  localparam int ADDR_W = 3;
  localparam logic REG_DELIMITER = 1'b0;
  localparam logic REG_COLUMN    = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ABSENT   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       line_done;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  delimiter;
    logic [15:0] column_number;
  } cfg_t;

endpackage

// ----- rtl/delimited_column_extractor.sv -----
// Top level of the delimited column extractor: input register, parser, result register.
//
//   channel | direction | handshake            | payload
//   in_     | in        | in_valid / in_ready  | in_item  (in_byte, line_end)
//   out_    | out       | out_valid / out_ready| out_item (out_byte, byte_valid, line_done, status)
//   cfg     | in/out    | APB psel/penable     | delimiter @0x0, column_number @0x4
//
// One item per clock sustained unless a result waits on a stalled result register.
// The parse state updates as an item leaves the input register, so throughput is set by
// that one stage. Items with no result leave even while the result register is stalled.
// Synchronous reset clears the line state, both valid flags and loads delimiter tab, column 1.
module delimited_column_extractor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  dce_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dce_pkg::out_item_t         out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dce_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import dce_pkg::*;

  cfg_t      cfg;
  logic      ib_vld_r;
  in_item_t  ib_item_r;
  logic      ob_vld_r;
  out_item_t ob_item_r;
  out_item_t res;
  logic      has_res;
  logic      adv;

  dce_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dce_line_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (ib_item_r),
    .fire    (adv),
    .res     (res),
    .has_res (has_res)
  );

  assign adv       = ib_vld_r && (!has_res || !ob_vld_r || out_ready);
  assign in_ready  = !ib_vld_r || adv;
  assign out_valid = ob_vld_r;
  assign out_item  = ob_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ib_vld_r <= 1'b0;
    end else if (in_ready) begin
      ib_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid)
      ib_item_r <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_vld_r <= 1'b0;
    end else if (adv && has_res) begin
      ob_vld_r <= 1'b1;
    end else if (out_ready) begin
      ob_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_res)
      ob_item_r <= res;
  end

endmodule

// ----- rtl/dce_cfg_regs.sv -----
// APB register file holding the delimiter and the column number.
module dce_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dce_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output dce_pkg::cfg_t              cfg
);
  import dce_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter     <= TAB_BYTE;
      cfg_r.column_number <= 16'd1;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_DELIMITER: cfg_r.delimiter     <= pwdata[7:0];
        REG_COLUMN:    cfg_r.column_number <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DELIMITER: prdata = {24'd0, cfg_r.delimiter};
      REG_COLUMN:    prdata = {16'd0, cfg_r.column_number};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/dce_line_parser.sv -----
// Per-line parse state and the combinational decision for one item.
module dce_line_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  dce_pkg::cfg_t      cfg,
  input  dce_pkg::in_item_t  item,
  input  logic               fire,
  output dce_pkg::out_item_t res,
  output logic               has_res
);
  import dce_pkg::*;

  logic             in_quotes_r,  in_quotes_nxt;
  logic [15:0]      delims_r,     delims_nxt;
  logic [FLD_W-1:0] fld_len_r,    fld_len_nxt;
  logic             overflow_r,   overflow_nxt;

  logic [15:0] skip;
  logic        is_quote, is_delim, selected, at_limit;
  logic [1:0]  line_status;

  assign skip     = (cfg.column_number == 16'd0) ? 16'd0 : cfg.column_number - 16'd1;
  assign is_quote = item.in_byte == QUOTE_BYTE;
  assign is_delim = item.in_byte == cfg.delimiter;
  assign selected = delims_r == skip;
  assign at_limit = fld_len_r == FLD_LAST;

  // Absent wins over overflow; an empty selected column ending the line is absent unless column_number is 0 or 1
  always_comb begin
    priority if (skip != 16'd0 && (delims_r < skip ||
                 (selected && fld_len_r == '0 && !overflow_r)))
      line_status = ST_ABSENT;
    else if (overflow_r)
      line_status = ST_OVERFLOW;
    else
      line_status = ST_OK;
  end

  always_comb begin
    in_quotes_nxt = in_quotes_r;
    delims_nxt    = delims_r;
    fld_len_nxt   = fld_len_r;
    overflow_nxt  = overflow_r;
    has_res       = 1'b0;
    res           = '0;
    priority if (item.line_end) begin
      has_res        = 1'b1;
      res.line_done  = 1'b1;
      res.status     = line_status;
      in_quotes_nxt  = 1'b0;
      delims_nxt     = '0;
      fld_len_nxt    = '0;
      overflow_nxt   = 1'b0;
    end else if (is_quote) begin
      in_quotes_nxt = !in_quotes_r;
    end else if (is_delim) begin
      if (!in_quotes_r && delims_r != DELIM_MAX)
        delims_nxt = delims_r + 16'd1;
    end else if (selected) begin
      if (at_limit) begin
        overflow_nxt = 1'b1;
      end else begin
        fld_len_nxt    = fld_len_r + FLD_W'(1);
        has_res        = 1'b1;
        res.out_byte   = item.in_byte;
        res.byte_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r <= 1'b0;
      delims_r    <= '0;
      fld_len_r   <= '0;
      overflow_r  <= 1'b0;
    end else if (fire) begin
      in_quotes_r <= in_quotes_nxt;
      delims_r    <= delims_nxt;
      fld_len_r   <= fld_len_nxt;
      overflow_r  <= overflow_nxt;
    end
  end

endmodule

// ----- rtl/dce_checker.sv -----
// Port-level checks for the delimited column extractor, bound to the top level.
module dce_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input dce_pkg::out_item_t out_item,
  input logic               pready
);
  import dce_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_byte_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.byte_valid |-> !out_item.line_done && out_item.status == ST_OK)
    else $error("byte result carries line status");

  a_line_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.line_done |-> out_item.out_byte == 8'd0 &&
      (out_item.status == ST_OK || out_item.status == ST_ABSENT ||
       out_item.status == ST_OVERFLOW))
    else $error("bad end-of-line result");

  a_out_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.byte_valid != out_item.line_done && pready)
    else $error("result item is neither byte nor line end");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind delimited_column_extractor dce_checker u_dce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item),
  .pready    (pready)
);

// ----- sim/tb_delimited_column_extractor.sv -----
// Testbench for delimited_column_extractor: directed and random lines checked against a predictor.
module tb_delimited_column_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  import dce_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    line_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   col_item;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  delimited_column_extractor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (line_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (col_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // predictor copy of registers and per-line parse state
  logic [7:0]  cfg_delim  = TAB_BYTE;
  logic [15:0] cfg_column = 16'd1;
  bit          in_quotes;
  logic [15:0] delims_seen;
  int          field_len;
  bit          overflowed;

  out_item_t col_results_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int lines_done    = 0;
  int bytes_done    = 0;
  int overflow_seen = 0;
  int absent_seen   = 0;
  int error_count   = 0;
  int cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               col_results_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic flag_error(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic void clear_line_state();
    in_quotes   = 1'b0;
    delims_seen = '0;
    field_len   = 0;
    overflowed  = 1'b0;
  endfunction

  // Advances the parse state by one item; returns 1 when the item yields a result.
  function automatic bit parse_column_item(input logic [7:0] b, input logic le,
                                           output out_item_t res);
    logic [15:0] skip;
    skip = (cfg_column == 16'd0) ? 16'd0 : cfg_column - 16'd1;
    res  = '0;
    if (le) begin
      res.line_done = 1'b1;
      if (skip != 0 && (delims_seen < skip ||
                        (delims_seen == skip && field_len == 0 && !overflowed)))
        res.status = ST_ABSENT;
      else if (overflowed)
        res.status = ST_OVERFLOW;
      else
        res.status = ST_OK;
      clear_line_state();
      return 1'b1;
    end
    if (b == QUOTE_BYTE) begin
      in_quotes = !in_quotes;
      return 1'b0;
    end
    if (b == cfg_delim) begin
      if (!in_quotes && delims_seen != DELIM_MAX)
        delims_seen++;
      return 1'b0;
    end
    if (delims_seen != skip)
      return 1'b0;
    if (field_len >= MAX_COLUMN_BYTES - 1) begin
      overflowed = 1'b1;
      return 1'b0;
    end
    field_len++;
    res.out_byte   = b;
    res.byte_valid = 1'b1;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (col_results_q.size() == 0) begin
        flag_error($sformatf("result %h with nothing outstanding", col_item));
      end else begin
        want = col_results_q.pop_front();
        if (col_item.out_byte !== want.out_byte)
          flag_error($sformatf("out_byte %h, want %h", col_item.out_byte, want.out_byte));
        if (col_item.byte_valid !== want.byte_valid)
          flag_error($sformatf("byte_valid %b, want %b", col_item.byte_valid,
                               want.byte_valid));
        if (col_item.line_done !== want.line_done)
          flag_error($sformatf("line_done %b, want %b", col_item.line_done,
                               want.line_done));
        if (col_item.status !== want.status)
          flag_error($sformatf("status %0d, want %0d", col_item.status, want.status));
        if (want.line_done) begin
          lines_done++;
          if (want.status == ST_OVERFLOW) overflow_seen++;
          if (want.status == ST_ABSENT) absent_seen++;
        end else begin
          bytes_done++;
        end
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic le);
    out_item_t res;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    line_item <= '{in_byte: b, line_end: le};
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (parse_column_item(b, le, res))
      col_results_q.push_back(res);
  endtask

  // Stop sending and let the pipeline empty before touching registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (col_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic idx, input logic wr, input logic [31:0] data,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic set_reg(input logic idx, input logic [31:0] val);
    logic [31:0] rd;
    wait_idle();
    apb_access(idx, 1'b1, val, rd);
    apb_access(idx, 1'b0, 32'd0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DELIMITER) begin
      cfg_delim = val[7:0];
      if (rd[7:0] !== cfg_delim)
        flag_error($sformatf("delimiter reads %h, want %h", rd[7:0], cfg_delim));
    end else begin
      cfg_column = val[15:0];
      if (rd[15:0] !== cfg_column)
        flag_error($sformatf("column_number reads %h, want %h", rd[15:0], cfg_column));
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] text_byte();
    if ($urandom_range(5) == 0)
      return 8'($urandom_range(255));
    return 8'($urandom_range(32, 126));
  endfunction

  task automatic send_random_line();
    int ncols;
    int len;
    ncols = $urandom_range(1, 6);
    for (int c = 0; c < ncols; c++) begin
      if (c != 0) send_item(cfg_delim, 1'b0);
      len = $urandom_range(0, 7);
      if ($urandom_range(5) == 0) begin
        // quoted run hiding a delimiter
        send_item(QUOTE_BYTE, 1'b0);
        send_item(text_byte(), 1'b0);
        send_item(cfg_delim, 1'b0);
        send_item(QUOTE_BYTE, 1'b0);
      end
      for (int i = 0; i < len; i++)
        send_item(text_byte(), 1'b0);
    end
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  // raw bytes with stray line ends, always closed by a line end
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 14);
    for (int i = 0; i < n; i++)
      send_item(8'($urandom_range(255)), ($urandom_range(99) < 15));
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic apply_random_config();
    logic [7:0]  d;
    logic [15:0] col;
    case ($urandom_range(7))
      0: d = TAB_BYTE;
      1: d = ",";
      2: d = ";";
      3: d = 8'h00;
      4: d = 8'hFF;
      5: d = QUOTE_BYTE;
      default: d = 8'($urandom_range(255));
    endcase
    case ($urandom_range(7))
      0: col = 16'd0;
      1: col = 16'd1;
      2: col = 16'd2;
      3: col = 16'd65535;
      default: col = 16'($urandom_range(1, 6));
    endcase
    set_reg(REG_DELIMITER, {24'($urandom_range(0, 32'hFF_FFFF)), d});
    set_reg(REG_COLUMN, {16'($urandom_range(0, 16'hFFFF)), col});
  endtask

  task automatic test_reset_defaults();
    // tab and column 1 straight out of reset
    send_text("A");
    send_item(TAB_BYTE, 1'b0);
    send_text("B");
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(TAB_BYTE, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_quotes_and_absent();
    set_reg(REG_DELIMITER, 32'h2C);
    set_reg(REG_COLUMN, 32'd2);
    send_text("a,\"b,c\"d");
    send_item(8'h00, 1'b1);
    send_text("a");              // too few delimiters
    send_item(8'h00, 1'b1);
    send_text("a,");             // empty last column
    send_item(8'h00, 1'b1);
    send_text("a,,");            // empty column followed by a delimiter
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_column_zero();
    set_reg(REG_COLUMN, 32'd0);
    send_text("q,r");
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_quote_as_delimiter();
    set_reg(REG_DELIMITER, {24'h0, QUOTE_BYTE});
    set_reg(REG_COLUMN, 32'd2);
    send_text("\"x\"y");
    send_item(8'h00, 1'b1);
    set_reg(REG_COLUMN, 32'd1);
    send_text("\"x\"y");
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_random_lines(input int n_items);
    int first;
    int next_cfg;
    first    = items_sent;
    next_cfg = first;
    while (items_sent - first < n_items) begin
      if (items_sent >= next_cfg) begin
        apply_random_config();
        next_cfg = items_sent + 150;
      end
      if ($urandom_range(4) != 0) send_random_line();
      else send_noise();
    end
    wait_idle();
  endtask

  initial begin
    clear_line_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 25;
    recv_idle_pct = 86;
    test_reset_defaults();
    test_quotes_and_absent();
    test_column_zero();
    test_quote_as_delimiter();
    test_random_lines(600);

    send_idle_pct = 86;
    recv_idle_pct = 25;
    test_random_lines(600);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_lines(600);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Sent %0d items over three idling patterns; checked %0d column bytes, %0d lines",
             items_sent, bytes_done, lines_done);
    $display("Lines with column absent: %0d, over length limit: %0d; %0d mismatches",
             absent_seen, overflow_seen, error_count);
    if (error_count == 0 && col_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
